### rtl/lro_pkg.sv
// lro_pkg: shared constants and types for the LRU replacement order block.
// Used by lro_ctrl, lro_datapath and lru_replacement_order; no dependencies.
`timescale 1ns / 1ps

package lro_pkg;

	localparam int LIST_DEPTH = 32;
	localparam int KEY_BITS   = 32;
	localparam int OCC_BITS   = $clog2(LIST_DEPTH + 1);

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [OCC_BITS-1:0] occ_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CMP  = 3'b010,
		ST_UPD  = 3'b100
	} state_t;

	typedef struct packed {
		logic load_key;
		logic compare;
		logic update;
	} dp_cmd_t;

endpackage

### rtl/lru_replacement_order.sv
// Each key passes through a compare state, which checks it against all stored
// slots in parallel, and an update state, which shifts the 32-entry key row and
// writes the key at the front. A new key may be started in the update state, so
// back-to-back keys need no idle state between them; busy is high only in the
// compare state. The result appears in the cycle after the update, strobed by
// done for exactly one cycle; the receiver cannot stall it. No clearing pass
// runs after reset. Depends on lro_pkg, lro_ctrl and lro_datapath.
`timescale 1ns / 1ps

module lru_replacement_order (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] use_key,
	output logic        busy,
	output logic        done,
	output logic        was_hit,
	output logic        evict_valid,
	output logic [31:0] evicted_key
);
	import lro_pkg::*;

	dp_cmd_t cmd;

	lro_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	lro_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.use_key     (use_key),
		.was_hit     (was_hit),
		.evict_valid (evict_valid),
		.evicted_key (evicted_key)
	);

endmodule

### rtl/lro_ctrl.sv
// lro_ctrl: sequencer that steps each key through compare and update.
// Depends on lro_pkg; drives lro_datapath through a command struct.
`timescale 1ns / 1ps

module lro_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output logic            done,
	output lro_pkg::dp_cmd_t cmd
);
	import lro_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   done_q;
	logic   accept;

	assign busy   = (state_q == ST_CMP);
	assign accept = start && !busy;
	assign done   = done_q;

	always_comb begin
		cmd.load_key = accept;
		cmd.compare  = (state_q == ST_CMP);
		cmd.update   = (state_q == ST_UPD);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_CMP;
			end
			ST_CMP: begin
				state_d = ST_UPD;
			end
			ST_UPD: begin
				state_d = start ? ST_CMP : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_UPD);
		end
	end

	a_done_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |=> done)
		else $error("result strobe missing after update");
	a_cmp_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_CMP))
		else $error("accepted transfer did not enter compare");
	a_upd_after_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |=> (state_q == ST_UPD))
		else $error("compare not followed by update");

endmodule

### rtl/lro_datapath.sv
// lro_datapath: recency-ordered key row with parallel compare and shift.
// Depends on lro_pkg; commanded by lro_ctrl.
`timescale 1ns / 1ps

module lro_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  lro_pkg::dp_cmd_t cmd,
	input  logic [31:0]      use_key,
	output logic             was_hit,
	output logic             evict_valid,
	output logic [31:0]      evicted_key
);
	import lro_pkg::*;

	key_t                  entry_q [LIST_DEPTH];
	key_t                  key_q;
	occ_t                  occ_q;
	logic [LIST_DEPTH-1:0] hit_vec_q;
	logic [LIST_DEPTH-1:0] match;
	logic [LIST_DEPTH-1:0] shift_en;
	logic                  hit;
	logic                  full;
	logic                  hit_q;
	logic                  evict_q;
	key_t                  evicted_q;

	assign hit  = |hit_vec_q;
	assign full = (occ_q == occ_t'(LIST_DEPTH));

	always_comb begin
		for (int i = 0; i < LIST_DEPTH; i++) begin
			match[i] = (entry_q[i] == key_q) && (occ_t'(i) < occ_q);
		end
	end

	// shift every slot up to the hit slot, or up to the fill level on a miss
	always_comb begin
		for (int i = 0; i < LIST_DEPTH; i++) begin
			shift_en[i] = hit ? (|(hit_vec_q >> i)) : (occ_t'(i) <= occ_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_key) key_q <= KEY_BITS'(use_key);
		if (cmd.update) begin
			entry_q[0] <= key_q;
			for (int i = 1; i < LIST_DEPTH; i++) begin
				if (shift_en[i]) entry_q[i] <= entry_q[i-1];
			end
			hit_q     <= hit;
			evict_q   <= !hit && full;
			evicted_q <= (!hit && full) ? entry_q[LIST_DEPTH-1] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q     <= '0;
			hit_vec_q <= '0;
		end else begin
			if (cmd.compare) hit_vec_q <= match;
			if (cmd.update && !hit && !full) occ_q <= occ_q + occ_t'(1);
		end
	end

	assign was_hit     = hit_q;
	assign evict_valid = evict_q;
	assign evicted_key = 32'(evicted_q);

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= occ_t'(LIST_DEPTH))
		else $error("occupancy above list depth");
	a_unique_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec_q))
		else $error("key stored in more than one slot");
	a_evict_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && !hit && full) |=> (evict_valid && full))
		else $error("eviction not reported on full miss");
	a_fill_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && !hit && !full) |=> (occ_q == $past(occ_q) + occ_t'(1)))
		else $error("fill level did not advance on miss");

endmodule

### bench/lro_scoreboard_pkg.sv
// lro_scoreboard_pkg: recency-list predictor and result checker for the LRU block bench.
// Depends on lro_pkg for LIST_DEPTH and key_t.
`timescale 1ns / 1ps

package lro_scoreboard_pkg;

	import lro_pkg::*;

	typedef struct {
		logic hit;
		logic evict;
		key_t gone;
	} lookup_result_t;

	class recency_scoreboard;
		key_t           recency[LIST_DEPTH];
		int             occupancy;
		lookup_result_t pending_results[$];
		int             mismatches;
		int             keys_sent;
		int             hits_seen;
		int             evictions_seen;
		int             results_checked;

		function new();
			occupancy = 0;
			mismatches = 0;
			keys_sent = 0;
			hits_seen = 0;
			evictions_seen = 0;
			results_checked = 0;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		// predict the list update for one accepted key
		function void note_key(key_t k);
			lookup_result_t r;
			int pos;
			r.hit = 1'b0;
			r.evict = 1'b0;
			r.gone = '0;
			pos = -1;
			for (int i = 0; i < occupancy; i++)
				if (pos < 0 && recency[i] == k)
					pos = i;
			if (pos >= 0) begin
				r.hit = 1'b1;
				for (int i = pos; i > 0; i--)
					recency[i] = recency[i-1];
				hits_seen++;
			end else if (occupancy == LIST_DEPTH) begin
				r.evict = 1'b1;
				r.gone = recency[LIST_DEPTH-1];
				for (int i = LIST_DEPTH - 1; i > 0; i--)
					recency[i] = recency[i-1];
				evictions_seen++;
			end else begin
				for (int i = occupancy; i > 0; i--)
					recency[i] = recency[i-1];
				occupancy++;
			end
			recency[0] = k;
			keys_sent++;
			pending_results.push_back(r);
		endfunction

		task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
			$display("tb: mismatch on %s: got %h, want %h", what, got, want);
			mismatches++;
		endtask

		task check_result(logic hit, logic evict, logic [31:0] gone);
			lookup_result_t w;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result transfer", {31'b0, hit}, 32'b0);
			end else begin
				w = pending_results.pop_front();
				results_checked++;
				if (hit !== w.hit)
					report_mismatch("was_hit", {31'b0, hit}, {31'b0, w.hit});
				if (evict !== w.evict)
					report_mismatch("evict_valid", {31'b0, evict}, {31'b0, w.evict});
				if (gone !== w.gone)
					report_mismatch("evicted_key", gone, w.gone);
			end
		endtask
	endclass

endpackage

### bench/tb_top.sv
// tb_top: drives keys into lru_replacement_order and checks every result transfer.
// Depends on lro_pkg, lro_scoreboard_pkg and the lru_replacement_order RTL.
`timescale 1ns / 1ps

module tb_top;

	import lro_pkg::*;
	import lro_scoreboard_pkg::*;

	localparam int RANDOM_KEYS = 650;
	localparam int POOL_SIZE   = 40;
	localparam int CYCLE_LIMIT = 60000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic [31:0] use_key;
	logic        busy;
	logic        done;
	logic        was_hit;
	logic        evict_valid;
	logic [31:0] evicted_key;

	recency_scoreboard board = new();
	int                cycle_count = 0;
	key_t              key_pool[POOL_SIZE];

	lru_replacement_order dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.use_key     (use_key),
		.busy        (busy),
		.done        (done),
		.was_hit     (was_hit),
		.evict_valid (evict_valid),
		.evicted_key (evicted_key)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			board.check_result(was_hit, evict_valid, evicted_key);
	end

	task automatic send_key(input key_t k);
		start <= 1'b1;
		use_key <= k;
		do @(posedge clk); while (busy !== 1'b0);
		board.note_key(k);
		@(negedge clk);
	endtask

	task automatic hold_off(input int cycles);
		start <= 1'b0;
		use_key <= $urandom;
		repeat (cycles) @(negedge clk);
	endtask

	initial begin
		key_t k;
		key_t last_key;
		int   pick;
		start = 1'b0;
		use_key = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_key(32'h0000_0000);
		send_key(32'hFFFF_FFFF);
		send_key(32'hFFFF_FFFF);
		send_key(32'h0000_0000);
		hold_off(1);
		send_key(32'h8000_0000);
		send_key(32'h0000_0001);
		send_key(32'h5555_5555);
		send_key(32'hAAAA_AAAA);
		send_key(32'h0000_0000);
		send_key(32'h0000_0001);
		hold_off(3);
		send_key(32'h8000_0000);
		send_key(32'h8000_0000);
		send_key(32'hFFFF_FFFF);
		send_key(32'h7FFF_FFFE);
		send_key(32'h5555_5555);

		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
		last_key = 32'h5555_5555;

		// mostly pool keys so hits land at every depth and the full list evicts
		for (int n = 0; n < RANDOM_KEYS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 10)
				k = last_key;
			else if (pick < 75)
				k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				k = $urandom;
			if ((n < 300 || n >= 450) && $urandom_range(0, 99) < 21)
				hold_off($urandom_range(1, 4));
			send_key(k);
			last_key = k;
		end
		start <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("tb: %0d keys transferred, %0d hits, %0d evictions, %0d results checked",
			board.keys_sent, board.hits_seen, board.evictions_seen, board.results_checked);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### files.f
rtl/lro_pkg.sv
rtl/lro_ctrl.sv
rtl/lro_datapath.sv
rtl/lru_replacement_order.sv
bench/lro_scoreboard_pkg.sv
bench/tb_top.sv
